FILE: hw/rtl/vha_pkg.sv
// vha_pkg: shared types, field widths, codes and reset values of the velocity histogram
// accumulator; no dependencies, used by vha_cfg, vha_ctrl, vha_dp and the top level
`timescale 1ns / 1ps
`default_nettype none
package vha_pkg;

	localparam int N_PROBES_DEF  = 4;
	localparam int N_ORIGINS_DEF = 4;
	localparam int N_SPECIES_DEF = 2;
	localparam int MAX_BINS_DEF  = 128;
	localparam int NUM_DIMS_DEF  = 3;

	localparam int CMD_W     = 2;
	localparam int PROBE_W   = 2;
	localparam int SPECIES_W = 1;
	localparam int ORIGIN_W  = 3;
	localparam int VEL_W     = 24;
	localparam int WEIGHT_W  = 32;
	localparam int VAR_W     = 3;
	localparam int BIN_W     = 7;
	localparam int COUNT_W   = 48;
	localparam int HIT_W     = 5;
	localparam int NB_CFG_W  = 8;
	localparam int BW_W      = 24;
	localparam int V2_W      = 48;
	localparam int ROOT_W    = V2_W / 2;
	localparam int REM_W     = ROOT_W + 1;
	localparam int DIV_W     = 48;
	localparam int ITER_W    = 6;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS  = DIV_W;

	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;
	localparam int REG_IDX_W = 3;

	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_V_MIN     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BW_V      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BW_SPEED  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BW_V2     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_NUM_BINS  = 3'd4;

	localparam logic signed [VEL_W-1:0] V_MIN_RST  = -24'sd1000;
	localparam logic [BW_W-1:0]         BW_V_RST   = 24'd21;
	localparam logic [BW_W-1:0]         BW_S_RST   = 24'd14;
	localparam logic [V2_W-1:0]         BW_V2_RST  = 48'd14285;
	localparam logic [NB_CFG_W-1:0]     NUM_BINS_RST = 8'd99;

	typedef struct packed {
		logic signed [VEL_W-1:0] v_min;
		logic [BW_W-1:0]         bw_v;
		logic [BW_W-1:0]         bw_speed;
		logic [V2_W-1:0]         bw_v2;
		logic [NB_CFG_W-1:0]     num_bins;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE       = 4'd0,
		OP_LOAD       = 4'd1,
		OP_SQ_MUL     = 4'd2,
		OP_SQ_ADD     = 4'd3,
		OP_SQRT_INIT  = 4'd4,
		OP_SQRT_STEP  = 4'd5,
		OP_DIV_INIT   = 4'd6,
		OP_DIV_STEP   = 4'd7,
		OP_DIV_END    = 4'd8,
		OP_ACC_RD     = 4'd9,
		OP_ACC_WR     = 4'd10,
		OP_RD_ISSUE   = 4'd11,
		OP_RD_OUT     = 4'd12,
		OP_CLR        = 4'd13,
		OP_RES_SAMPLE = 4'd14,
		OP_RES_ZERO   = 4'd15
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [VAR_W-1:0] sel;
		logic             slot_total;
	} dp_cmd_t;

	typedef struct packed {
		logic item_ok;
		logic var_hit;
		logic clr_last;
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/velocity_histogram_accumulator.sv
// velocity_histogram_accumulator: top level joining apb registers, sequencer and datapath
// depends on vha_pkg, vha_cfg, vha_ctrl, vha_dp, vha_ram
// a sample runs one squarer pass, 24 square-root steps, five 48-step divides and
// two ram read-modify-writes per hit
// clear: one store entry per cycle; one transaction at a time
// reset: after arst_n the whole store (25600 entries by default) is zeroed
// while busy is high; results are strobed on done for one cycle and cannot be stalled
`timescale 1ns / 1ps
`default_nettype none
module velocity_histogram_accumulator #(
	parameter int N_PROBES  = vha_pkg::N_PROBES_DEF,
	parameter int N_ORIGINS = vha_pkg::N_ORIGINS_DEF,
	parameter int N_SPECIES = vha_pkg::N_SPECIES_DEF,
	parameter int MAX_BINS  = vha_pkg::MAX_BINS_DEF,
	parameter int NUM_DIMS  = vha_pkg::NUM_DIMS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [vha_pkg::PADDR_W-1:0]          paddr,
	input  wire logic [vha_pkg::PDATA_W-1:0]          pwdata,
	output logic      [vha_pkg::PDATA_W-1:0]          prdata,
	output logic                                      pready,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [vha_pkg::CMD_W-1:0]            cmd,
	input  wire logic [vha_pkg::PROBE_W-1:0]          probe,
	input  wire logic [vha_pkg::SPECIES_W-1:0]        species,
	input  wire logic [vha_pkg::ORIGIN_W-1:0]         origin,
	input  wire logic signed [vha_pkg::VEL_W-1:0]     vel_x,
	input  wire logic signed [vha_pkg::VEL_W-1:0]     vel_y,
	input  wire logic signed [vha_pkg::VEL_W-1:0]     vel_z,
	input  wire logic [vha_pkg::WEIGHT_W-1:0]         weight,
	input  wire logic [vha_pkg::VAR_W-1:0]            variable,
	input  wire logic [vha_pkg::BIN_W-1:0]            bin,
	output logic                                      done,
	output logic      [vha_pkg::COUNT_W-1:0]          count,
	output logic      [vha_pkg::HIT_W-1:0]            hit_mask
);

	vha_pkg::cfg_t    cfg;
	vha_pkg::dp_cmd_t dcmd;
	vha_pkg::dp_sts_t sts;

	vha_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	vha_ctrl #(
		.NUM_DIMS(NUM_DIMS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.sts   (sts),
		.dcmd  (dcmd),
		.busy  (busy),
		.done  (done)
	);

	vha_dp #(
		.N_PROBES (N_PROBES),
		.N_ORIGINS(N_ORIGINS),
		.N_SPECIES(N_SPECIES),
		.MAX_BINS (MAX_BINS),
		.NUM_DIMS (NUM_DIMS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.dcmd    (dcmd),
		.sts     (sts),
		.cfg     (cfg),
		.probe   (probe),
		.species (species),
		.origin  (origin),
		.vel_x   (vel_x),
		.vel_y   (vel_y),
		.vel_z   (vel_z),
		.weight  (weight),
		.variable(variable),
		.bin     (bin),
		.count   (count),
		.hit_mask(hit_mask)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/vha_ram.sv
// vha_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module vha_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 25600
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/vha_cfg.sv
// vha_cfg: apb register file holding the binning configuration
// depends on vha_pkg
`timescale 1ns / 1ps
`default_nettype none
module vha_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [vha_pkg::PADDR_W-1:0] paddr,
	input  wire logic [vha_pkg::PDATA_W-1:0] pwdata,
	output logic      [vha_pkg::PDATA_W-1:0] prdata,
	output logic                             pready,
	output vha_pkg::cfg_t                    cfg
);

	vha_pkg::cfg_t cfg_q;
	logic [vha_pkg::REG_IDX_W-1:0] idx;
	logic wr;

	assign idx    = paddr[vha_pkg::PADDR_W-1:3];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.v_min    <= vha_pkg::V_MIN_RST;
			cfg_q.bw_v     <= vha_pkg::BW_V_RST;
			cfg_q.bw_speed <= vha_pkg::BW_S_RST;
			cfg_q.bw_v2    <= vha_pkg::BW_V2_RST;
			cfg_q.num_bins <= vha_pkg::NUM_BINS_RST;
		end else if (wr) begin
			case (idx)
				vha_pkg::REG_V_MIN:    cfg_q.v_min    <= pwdata[vha_pkg::VEL_W-1:0];
				vha_pkg::REG_BW_V:     cfg_q.bw_v     <= pwdata[vha_pkg::BW_W-1:0];
				vha_pkg::REG_BW_SPEED: cfg_q.bw_speed <= pwdata[vha_pkg::BW_W-1:0];
				vha_pkg::REG_BW_V2:    cfg_q.bw_v2    <= pwdata[vha_pkg::V2_W-1:0];
				vha_pkg::REG_NUM_BINS: cfg_q.num_bins <= pwdata[vha_pkg::NB_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			vha_pkg::REG_V_MIN:    prdata = vha_pkg::PDATA_W'(cfg_q.v_min);
			vha_pkg::REG_BW_V:     prdata = vha_pkg::PDATA_W'(cfg_q.bw_v);
			vha_pkg::REG_BW_SPEED: prdata = vha_pkg::PDATA_W'(cfg_q.bw_speed);
			vha_pkg::REG_BW_V2:    prdata = vha_pkg::PDATA_W'(cfg_q.bw_v2);
			vha_pkg::REG_NUM_BINS: prdata = vha_pkg::PDATA_W'(cfg_q.num_bins);
			default:               prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: hw/rtl/vha_ctrl.sv
// vha_ctrl: sequencer for sample, read and clear transactions
// depends on vha_pkg; drives vha_dp through command and status structs
`timescale 1ns / 1ps
`default_nettype none
module vha_ctrl #(
	parameter int NUM_DIMS = vha_pkg::NUM_DIMS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [vha_pkg::CMD_W-1:0] cmd,
	input  vha_pkg::dp_sts_t               sts,
	output vha_pkg::dp_cmd_t               dcmd,
	output logic                           busy,
	output logic                           done
);

	localparam int NVARS = NUM_DIMS + 2;

	typedef enum logic [14:0] {
		S_CLR        = 15'b000000000000001,
		S_IDLE       = 15'b000000000000010,
		S_DISP       = 15'b000000000000100,
		S_SQ_MUL     = 15'b000000000001000,
		S_SQ_ADD     = 15'b000000000010000,
		S_SQRT_INIT  = 15'b000000000100000,
		S_SQRT       = 15'b000000001000000,
		S_DIV_INIT   = 15'b000000010000000,
		S_DIV        = 15'b000000100000000,
		S_DIV_END    = 15'b000001000000000,
		S_ACC_RD     = 15'b000010000000000,
		S_ACC_WR     = 15'b000100000000000,
		S_RD_ISSUE   = 15'b001000000000000,
		S_RD_OUT     = 15'b010000000000000,
		S_RES        = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;
	logic [vha_pkg::VAR_W-1:0]  sel_q, sel_d;
	logic                       slot_q, slot_d;
	logic [vha_pkg::ITER_W-1:0] iter_q, iter_d;
	logic [vha_pkg::CMD_W-1:0]  cmd_q, cmd_d;
	logic                       clr_cmd_q, clr_cmd_d;
	logic                       res_smp_q, res_smp_d;
	logic                       done_q;
	logic                       last_var;

	assign last_var = (sel_q == vha_pkg::VAR_W'(NVARS - 1));
	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		state_d   = state_q;
		sel_d     = sel_q;
		slot_d    = slot_q;
		iter_d    = iter_q;
		cmd_d     = cmd_q;
		clr_cmd_d = clr_cmd_q;
		res_smp_d = res_smp_q;
		dcmd.op   = vha_pkg::OP_NONE;
		dcmd.sel  = sel_q;
		dcmd.slot_total = slot_q;
		case (state_q)
			S_CLR: begin
				dcmd.op = vha_pkg::OP_CLR;
				if (sts.clr_last) begin
					res_smp_d = 1'b0;
					state_d = clr_cmd_q ? S_RES : S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					dcmd.op = vha_pkg::OP_LOAD;
					cmd_d   = cmd;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				sel_d  = '0;
				slot_d = 1'b0;
				res_smp_d = 1'b0;
				case (cmd_q)
					vha_pkg::CMD_SAMPLE: state_d = sts.item_ok ? S_SQ_MUL : S_RES;
					vha_pkg::CMD_READ:   state_d = S_RD_ISSUE;
					vha_pkg::CMD_CLEAR: begin
						clr_cmd_d = 1'b1;
						state_d   = S_CLR;
					end
					default: state_d = S_RES;
				endcase
			end
			S_SQ_MUL: begin
				dcmd.op = vha_pkg::OP_SQ_MUL;
				state_d = S_SQ_ADD;
			end
			S_SQ_ADD: begin
				dcmd.op = vha_pkg::OP_SQ_ADD;
				if (sel_q == vha_pkg::VAR_W'(NUM_DIMS - 1)) begin
					state_d = S_SQRT_INIT;
				end else begin
					sel_d   = sel_q + 1'b1;
					state_d = S_SQ_MUL;
				end
			end
			S_SQRT_INIT: begin
				dcmd.op = vha_pkg::OP_SQRT_INIT;
				iter_d  = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				dcmd.op = vha_pkg::OP_SQRT_STEP;
				iter_d  = iter_q + 1'b1;
				if (iter_q == vha_pkg::ITER_W'(vha_pkg::SQRT_STEPS - 1)) begin
					sel_d   = '0;
					state_d = S_DIV_INIT;
				end
			end
			S_DIV_INIT: begin
				dcmd.op = vha_pkg::OP_DIV_INIT;
				iter_d  = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				dcmd.op = vha_pkg::OP_DIV_STEP;
				iter_d  = iter_q + 1'b1;
				if (iter_q == vha_pkg::ITER_W'(vha_pkg::DIV_STEPS - 1)) begin
					state_d = S_DIV_END;
				end
			end
			S_DIV_END: begin
				dcmd.op = vha_pkg::OP_DIV_END;
				if (last_var) begin
					sel_d   = '0;
					slot_d  = 1'b0;
					state_d = S_ACC_RD;
				end else begin
					sel_d   = sel_q + 1'b1;
					state_d = S_DIV_INIT;
				end
			end
			S_ACC_RD: begin
				if (sts.var_hit) begin
					dcmd.op = vha_pkg::OP_ACC_RD;
					state_d = S_ACC_WR;
				end else if (last_var) begin
					res_smp_d = 1'b1;
					state_d   = S_RES;
				end else begin
					sel_d = sel_q + 1'b1;
				end
			end
			S_ACC_WR: begin
				dcmd.op = vha_pkg::OP_ACC_WR;
				state_d = S_ACC_RD;
				if (!slot_q) begin
					slot_d = 1'b1;
				end else begin
					slot_d = 1'b0;
					if (last_var) begin
						res_smp_d = 1'b1;
						state_d   = S_RES;
					end else begin
						sel_d = sel_q + 1'b1;
					end
				end
			end
			S_RD_ISSUE: begin
				dcmd.op = vha_pkg::OP_RD_ISSUE;
				state_d = S_RD_OUT;
			end
			S_RD_OUT: begin
				dcmd.op = vha_pkg::OP_RD_OUT;
				state_d = S_IDLE;
			end
			S_RES: begin
				dcmd.op   = res_smp_q ? vha_pkg::OP_RES_SAMPLE : vha_pkg::OP_RES_ZERO;
				clr_cmd_d = 1'b0;
				state_d   = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			sel_q     <= '0;
			slot_q    <= 1'b0;
			iter_q    <= '0;
			cmd_q     <= '0;
			clr_cmd_q <= 1'b0;
			res_smp_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			sel_q     <= sel_d;
			slot_q    <= slot_d;
			iter_q    <= iter_d;
			cmd_q     <= cmd_d;
			clr_cmd_q <= clr_cmd_d;
			res_smp_q <= res_smp_d;
			done_q    <= (state_q == S_RD_OUT) || (state_q == S_RES);
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/vha_dp.sv
// vha_dp: datapath with squarer, digit-serial square root, serial divider,
// histogram ram and result registers; depends on vha_pkg and vha_ram
`timescale 1ns / 1ps
`default_nettype none
module vha_dp #(
	parameter int N_PROBES  = vha_pkg::N_PROBES_DEF,
	parameter int N_ORIGINS = vha_pkg::N_ORIGINS_DEF,
	parameter int N_SPECIES = vha_pkg::N_SPECIES_DEF,
	parameter int MAX_BINS  = vha_pkg::MAX_BINS_DEF,
	parameter int NUM_DIMS  = vha_pkg::NUM_DIMS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  vha_pkg::dp_cmd_t                          dcmd,
	output vha_pkg::dp_sts_t                          sts,
	input  vha_pkg::cfg_t                             cfg,
	input  wire logic [vha_pkg::PROBE_W-1:0]          probe,
	input  wire logic [vha_pkg::SPECIES_W-1:0]        species,
	input  wire logic [vha_pkg::ORIGIN_W-1:0]         origin,
	input  wire logic signed [vha_pkg::VEL_W-1:0]     vel_x,
	input  wire logic signed [vha_pkg::VEL_W-1:0]     vel_y,
	input  wire logic signed [vha_pkg::VEL_W-1:0]     vel_z,
	input  wire logic [vha_pkg::WEIGHT_W-1:0]         weight,
	input  wire logic [vha_pkg::VAR_W-1:0]            variable,
	input  wire logic [vha_pkg::BIN_W-1:0]            bin,
	output logic      [vha_pkg::COUNT_W-1:0]          count,
	output logic      [vha_pkg::HIT_W-1:0]            hit_mask
);

	localparam int NVARS  = NUM_DIMS + 2;
	localparam int NSLOTS = N_ORIGINS + 1;
	localparam int DEPTH  = N_PROBES * NSLOTS * N_SPECIES * NVARS * MAX_BINS;
	localparam int AW     = $clog2(DEPTH);
	localparam int BIN_AW = $clog2(MAX_BINS);
	localparam int NB_W   = $clog2(MAX_BINS + 1);
	localparam int VW     = vha_pkg::VEL_W;
	localparam int CW     = vha_pkg::COUNT_W;
	localparam int DW     = vha_pkg::DIV_W;
	localparam int RW     = vha_pkg::ROOT_W;
	localparam int MW     = vha_pkg::REM_W;
	localparam logic [CW-1:0] SAT_MAX = {CW{1'b1}};

	logic [vha_pkg::PROBE_W-1:0]   probe_q;
	logic [vha_pkg::SPECIES_W-1:0] species_q;
	logic [vha_pkg::ORIGIN_W-1:0]  origin_q;
	logic signed [VW-1:0]          vel_q [3];
	logic [vha_pkg::WEIGHT_W-1:0]  weight_q;
	logic [vha_pkg::VAR_W-1:0]     variable_q;
	logic [vha_pkg::BIN_W-1:0]     bin_q;

	logic [vha_pkg::V2_W-1:0] prod_s1;
	logic [vha_pkg::V2_W-1:0] v2_q;
	logic [vha_pkg::V2_W-1:0] sx_q;
	logic [MW-1:0]            rem_q;
	logic [RW-1:0]            root_q;
	logic [DW-1:0]            dq_q;
	logic [DW-1:0]            drem_q;
	logic [DW-1:0]            dvs_q;
	logic                     neg_q;
	logic [vha_pkg::HIT_W-1:0] ok_q;
	logic [BIN_AW-1:0]        bin_idx_q [vha_pkg::HIT_W];
	logic [AW-1:0]            clr_cnt_q;
	logic                     rd_ok_q;
	logic [CW-1:0]            count_q;
	logic [vha_pkg::HIT_W-1:0] hit_q;

	logic [NB_W-1:0]        nb;
	logic signed [VW-1:0]   vsel;
	logic [VW-1:0]          mag;
	logic signed [VW:0]     diff;
	logic [1:0]             top2;
	logic [RW+2:0]          trial;
	logic [DW:0]            dshift;
	logic [DW:0]            dsub;
	logic                   read_ok;
	logic [31:0]            a_row;
	logic [31:0]            a_full;
	logic [31:0]            a_var;
	logic [31:0]            a_org;
	logic [31:0]            a_bin;
	logic [AW-1:0]          addr;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [CW-1:0]          ram_wdata;
	logic [CW-1:0]          ram_rdata;
	logic [CW:0]            acc_sum;

	assign nb = (32'(cfg.num_bins) > 32'(MAX_BINS)) ? NB_W'(MAX_BINS) : NB_W'(cfg.num_bins);

	assign vsel = (dcmd.sel < vha_pkg::VAR_W'(NUM_DIMS)) ? vel_q[dcmd.sel[1:0]] : '0;
	assign mag  = vsel[VW-1] ? VW'(-vsel) : VW'(vsel);
	assign diff = {vsel[VW-1], vsel} - {cfg.v_min[VW-1], cfg.v_min};

	assign top2  = sx_q[vha_pkg::V2_W-1 -: 2];
	assign trial = {rem_q, top2} - {1'b0, root_q, 2'b01};

	assign dshift = {drem_q, dq_q[DW-1]};
	assign dsub   = dshift - {1'b0, dvs_q};

	assign sts.item_ok = (32'(probe_q) < 32'(N_PROBES)) && (32'(species_q) < 32'(N_SPECIES))
		&& (32'(origin_q) < 32'(N_ORIGINS));
	assign sts.var_hit = ok_q[dcmd.sel];
	assign sts.clr_last = (clr_cnt_q == AW'(DEPTH - 1));

	assign read_ok = (32'(probe_q) < 32'(N_PROBES)) && (32'(species_q) < 32'(N_SPECIES))
		&& (32'(origin_q) <= 32'(N_ORIGINS)) && (32'(variable_q) < 32'(NVARS))
		&& (32'(bin_q) < 32'(nb));

	always_comb begin
		if (dcmd.op == vha_pkg::OP_RD_ISSUE) begin
			a_var = 32'(variable_q);
			a_org = 32'(origin_q);
			a_bin = 32'(bin_q);
		end else begin
			a_var = 32'(dcmd.sel);
			a_org = dcmd.slot_total ? 32'(N_ORIGINS) : 32'(origin_q);
			a_bin = 32'(bin_idx_q[dcmd.sel]);
		end
		a_row  = ((32'(probe_q) * 32'(NSLOTS) + a_org) * 32'(N_SPECIES) + 32'(species_q))
			* 32'(NVARS) + a_var;
		a_full = a_row * 32'(MAX_BINS) + a_bin;
		addr   = a_full[AW-1:0];
	end

	assign acc_sum = {1'b0, ram_rdata} + (CW + 1)'(weight_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr;
		ram_wdata = acc_sum[CW] ? SAT_MAX : acc_sum[CW-1:0];
		if (dcmd.op == vha_pkg::OP_CLR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else if (dcmd.op == vha_pkg::OP_ACC_WR) begin
			ram_we = 1'b1;
		end
	end

	vha_ram #(
		.WIDTH(CW),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		case (dcmd.op)
			vha_pkg::OP_LOAD: begin
				probe_q    <= probe;
				species_q  <= species;
				origin_q   <= origin;
				vel_q[0]   <= vel_x;
				vel_q[1]   <= vel_y;
				vel_q[2]   <= vel_z;
				weight_q   <= weight;
				variable_q <= variable;
				bin_q      <= bin;
				v2_q       <= '0;
			end
			vha_pkg::OP_SQ_MUL: prod_s1 <= mag * mag;
			vha_pkg::OP_SQ_ADD: v2_q <= v2_q + prod_s1;
			vha_pkg::OP_SQRT_INIT: begin
				sx_q   <= v2_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			vha_pkg::OP_SQRT_STEP: begin
				sx_q <= {sx_q[vha_pkg::V2_W-3:0], 2'b00};
				if (!trial[RW+2]) begin
					rem_q  <= trial[MW-1:0];
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= {rem_q[MW-3:0], top2};
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			vha_pkg::OP_DIV_INIT: begin
				drem_q <= '0;
				if (dcmd.sel < vha_pkg::VAR_W'(NUM_DIMS)) begin
					dq_q  <= DW'(diff[VW-1:0]);
					dvs_q <= DW'(cfg.bw_v);
					neg_q <= diff[VW];
				end else if (dcmd.sel == vha_pkg::VAR_W'(NUM_DIMS)) begin
					dq_q  <= DW'(root_q);
					dvs_q <= DW'(cfg.bw_speed);
					neg_q <= 1'b0;
				end else begin
					dq_q  <= v2_q;
					dvs_q <= cfg.bw_v2;
					neg_q <= 1'b0;
				end
			end
			vha_pkg::OP_DIV_STEP: begin
				if (!dsub[DW]) begin
					drem_q <= dsub[DW-1:0];
					dq_q   <= {dq_q[DW-2:0], 1'b1};
				end else begin
					drem_q <= dshift[DW-1:0];
					dq_q   <= {dq_q[DW-2:0], 1'b0};
				end
			end
			vha_pkg::OP_DIV_END: bin_idx_q[dcmd.sel] <= dq_q[BIN_AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q      <= '0;
			clr_cnt_q <= '0;
			rd_ok_q   <= 1'b0;
			count_q   <= '0;
			hit_q     <= '0;
		end else begin
			case (dcmd.op)
				vha_pkg::OP_LOAD: ok_q <= '0;
				vha_pkg::OP_DIV_END: ok_q[dcmd.sel] <= !neg_q && (dq_q < DW'(nb));
				vha_pkg::OP_CLR: clr_cnt_q <= sts.clr_last ? '0 : clr_cnt_q + 1'b1;
				vha_pkg::OP_RD_ISSUE: rd_ok_q <= read_ok;
				vha_pkg::OP_RD_OUT: begin
					count_q <= rd_ok_q ? ram_rdata : '0;
					hit_q   <= '0;
				end
				vha_pkg::OP_RES_SAMPLE: begin
					count_q <= '0;
					hit_q   <= ok_q;
				end
				vha_pkg::OP_RES_ZERO: begin
					count_q <= '0;
					hit_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	assign count    = count_q;
	assign hit_mask = hit_q;

endmodule
`default_nettype wire
